// File: rtl/sstint_pkg.sv
// Package: shared constants and codes for the sorted-sample trapezoid integrator.
package sstint_pkg;

    // Default number of table entries
    localparam int DEF_TABLE_DEPTH = 256;

    // Fewest stored points that give at least one segment
    localparam int MIN_POINTS = 2;

    // Item function codes
    typedef enum logic {
        FN_ADD = 1'b0,
        FN_INT = 1'b1
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_FEW  = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_INT_FIRST,
        S_INT_NEXT,
        S_SEG,
        S_LA_MUL,
        S_LA_DIV,
        S_LB_MUL,
        S_LB_DIV,
        S_AR_PREP,
        S_AR_MUL,
        S_AR_ACC,
        S_ADV,
        S_FIN
    } t_state;

    localparam int DIV_STEPS = 64;

endpackage

// File: rtl/sorted_sample_trapezoid_integrator_top.sv
// Top level: sorted (x, y) point table with ordered insert and trapezoid-rule integration.
// Add: shifts each entry that sorts after the new point up one place, then writes the point.
// Integrate: reads the first point, then walks each segment; a segment in range adds its
// trapezoid, and a segment clipped by a bound runs the bit-serial 64/32 divider per bound.
// Busy falls as the one-cycle strobe o_valid rises; a full-table add or a short-table
// integrate answers in the cycle after accept. Synchronous reset empties the table at once.
module sorted_sample_trapezoid_integrator_top #(
    parameter int TABLE_DEPTH = sstint_pkg::DEF_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_func,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_lower_bound,
    input  logic signed [31:0] i_upper_bound,
    output logic               o_valid,
    output logic signed [63:0] o_area,
    output logic [1:0]         o_status,
    output logic [8:0]         o_point_count
);
    import sstint_pkg::*;

    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ACC_W = 65 + $clog2(TABLE_DEPTH);

    t_state r_state, n_state;
    logic   r_done;

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;

    logic signed [31:0] r_nx, r_ny, r_a, r_b;
    logic signed [31:0] r_p1x, r_p1y, r_p2x, r_p2y;
    logic signed [31:0] r_y1c, r_y2c;
    logic               r_ca, r_cb;
    logic [31:0]        r_dx, r_dym;
    logic               r_dyn;
    logic [63:0]        r_prod;
    logic [31:0]        r_rem;
    logic [5:0]         r_dcnt;
    logic [31:0]        r_wm;
    logic [32:0]        r_sm;
    logic               r_neg;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [63:0] r_area;
    t_status            r_status;

    // Point table: x in the high half, y in the low half
    logic [63:0]   mem [TABLE_DEPTH];
    logic [63:0]   r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [63:0]   mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    // Decoded read word and insert compare
    logic signed [31:0] rd_x, rd_y;
    logic               rd_after;
    logic [CW-1:0]      idx_m1, idx_p1, cnt_m1;
    logic               accept;

    assign rd_x     = r_rd_data[63:32];
    assign rd_y     = r_rd_data[31:0];
    assign rd_after = (rd_x > r_nx) || ((rd_x == r_nx) && (rd_y > r_ny));
    assign idx_m1   = r_idx - 1'b1;
    assign idx_p1   = r_idx + 1'b1;
    assign cnt_m1   = r_cnt - 1'b1;
    assign accept   = start && !busy;

    // Segment conditions on the unclipped endpoints
    logic seg_ca, seg_cb, seg_in;
    assign seg_ca = (r_p1x < r_a) && (r_p2x >= r_a);
    assign seg_cb = (r_p1x < r_b) && (r_p2x >= r_b);
    assign seg_in = (r_p1x < r_b) && (r_p2x >= r_a);

    // Shared 32x32 multiplier
    logic [32:0] diff_la, diff_lb;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign diff_la = 33'($signed(r_a)) - 33'($signed(r_p1x));
    assign diff_lb = 33'($signed(r_p2x)) - 33'($signed(r_b));

    always_comb begin
        mul_a = r_dym;
        mul_b = diff_la[31:0];
        unique case (r_state)
            S_LB_MUL: mul_b = diff_lb[31:0];
            S_AR_MUL: begin
                mul_a = r_wm;
                mul_b = r_sm[31:0];
            end
            default: ;
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Restoring divider step: remainder stays below the divisor
    logic [32:0] div_sh;
    logic        div_ge;
    logic [32:0] div_sub;
    logic [31:0] div_q;
    logic        div_last;
    logic signed [33:0] q_signed;
    assign div_sh   = {r_rem, r_prod[63]};
    assign div_ge   = div_sh >= {1'b0, r_dx};
    assign div_sub  = div_sh - {1'b0, r_dx};
    assign div_q    = {r_prod[30:0], div_ge};
    assign div_last = (r_dcnt == 6'(DIV_STEPS - 1));
    assign q_signed = r_dyn ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});

    // Clipped width and height sum
    logic signed [31:0] x1c, x2c;
    logic signed [32:0] w_s, s_s;
    assign x1c = r_ca ? r_a : r_p1x;
    assign x2c = r_cb ? r_b : r_p2x;
    assign w_s = 33'(x2c) - 33'(x1c);
    assign s_s = 33'(r_y1c) + 33'(r_y2c);

    // Trapezoid term
    logic [63:0] ar_m;
    logic [62:0] ar_half;
    logic signed [ACC_W-1:0] ar_term;
    assign ar_m    = r_prod + (r_sm[32] ? {r_wm, 32'd0} : 64'd0);
    assign ar_half = ar_m[63:1];
    assign ar_term = r_neg ? -$signed(ACC_W'(ar_half)) : $signed(ACC_W'(ar_half));

    // Saturation check
    logic acc_fits;
    assign acc_fits = (r_acc[ACC_W-1:63] == '0) || (r_acc[ACC_W-1:63] == '1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FN_ADD) begin
                        if (r_cnt >= CW'(TABLE_DEPTH)) n_state = S_IDLE;
                        else if (r_cnt == '0)          n_state = S_INS_PUT;
                        else                           n_state = S_INS_RD;
                    end else begin
                        if (r_cnt < CW'(MIN_POINTS)) n_state = S_IDLE;
                        else                         n_state = S_INT_FIRST;
                    end
                end
            end
            S_INS_RD:  n_state = S_INS_CMP;
            S_INS_CMP: begin
                if (!rd_after)        n_state = S_IDLE;
                else if (idx_m1 == '0) n_state = S_INS_PUT;
                else                   n_state = S_INS_RD;
            end
            S_INS_PUT:   n_state = S_IDLE;
            S_INT_FIRST: n_state = S_INT_NEXT;
            S_INT_NEXT:  n_state = S_SEG;
            S_SEG: begin
                if (!seg_in)     n_state = S_ADV;
                else if (seg_ca) n_state = S_LA_MUL;
                else if (seg_cb) n_state = S_LB_MUL;
                else             n_state = S_AR_PREP;
            end
            S_LA_MUL: n_state = S_LA_DIV;
            S_LA_DIV: begin
                if (div_last) n_state = r_cb ? S_LB_MUL : S_AR_PREP;
            end
            S_LB_MUL: n_state = S_LB_DIV;
            S_LB_DIV: begin
                if (div_last) n_state = S_AR_PREP;
            end
            S_AR_PREP: n_state = S_AR_MUL;
            S_AR_MUL:  n_state = S_AR_ACC;
            S_AR_ACC:  n_state = S_ADV;
            S_ADV:     n_state = (r_idx == cnt_m1) ? S_FIN : S_INT_NEXT;
            S_FIN:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Outputs and memory controls
    always_comb begin
        busy   = (r_state != S_IDLE);
        mem_we = 1'b0;
        mem_wa = r_idx[AW-1:0];
        mem_wd = {r_nx, r_ny};
        mem_ra = '0;
        unique case (r_state)
            S_INS_RD: mem_ra = idx_m1[AW-1:0];
            S_INS_CMP: begin
                mem_we = 1'b1;
                if (rd_after) mem_wd = r_rd_data;
            end
            S_INS_PUT:   mem_we = 1'b1;
            S_INT_FIRST: mem_ra = r_idx[AW-1:0];
            S_ADV:       mem_ra = idx_p1[AW-1:0];
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state != S_IDLE) && (n_state == S_IDLE) ||
                       (accept && (n_state == S_IDLE));
            if ((r_state == S_INS_PUT) || ((r_state == S_INS_CMP) && !rd_after)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_nx     <= i_point_x;
                r_ny     <= i_point_y;
                r_a      <= i_lower_bound;
                r_b      <= i_upper_bound;
                r_area   <= '0;
                r_acc    <= '0;
                r_idx    <= (i_func == FN_ADD) ? r_cnt : CW'(1);
                r_status <= ST_OK;
                if (i_func == FN_ADD && r_cnt >= CW'(TABLE_DEPTH)) r_status <= ST_FULL;
                if (i_func == FN_INT && r_cnt < CW'(MIN_POINTS))   r_status <= ST_FEW;
            end
            S_INS_CMP: begin
                if (rd_after) r_idx <= idx_m1;
            end
            S_INT_FIRST: begin
                r_p1x <= rd_x;
                r_p1y <= rd_y;
            end
            S_INT_NEXT: begin
                r_p2x <= rd_x;
                r_p2y <= rd_y;
            end
            S_SEG: begin
                logic [32:0] dx33, dy33;
                dx33  = 33'($signed(r_p2x)) - 33'($signed(r_p1x));
                dy33  = 33'($signed(r_p2y)) - 33'($signed(r_p1y));
                r_ca  <= seg_ca;
                r_cb  <= seg_cb;
                r_dx  <= dx33[31:0];
                r_dyn <= dy33[32];
                r_dym <= dy33[32] ? 32'(-dy33) : dy33[31:0];
                r_y1c <= r_p1y;
                r_y2c <= r_p2y;
            end
            S_LA_MUL, S_LB_MUL: begin
                r_prod <= mul_p;
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            S_LA_DIV, S_LB_DIV: begin
                r_rem  <= div_ge ? div_sub[31:0] : div_sh[31:0];
                r_prod <= {r_prod[62:0], div_ge};
                r_dcnt <= r_dcnt + 1'b1;
                if (div_last) begin
                    if (r_state == S_LA_DIV) r_y1c <= 32'(34'(r_p1y) + q_signed);
                    else                     r_y2c <= 32'(34'(r_p2y) - q_signed);
                end
            end
            S_AR_PREP: begin
                r_wm  <= w_s[32] ? 32'(-w_s) : w_s[31:0];
                r_sm  <= s_s[32] ? -s_s : s_s;
                r_neg <= w_s[32] ^ s_s[32];
            end
            S_AR_MUL: r_prod <= mul_p;
            S_AR_ACC: r_acc  <= r_acc + ar_term;
            S_ADV: begin
                r_p1x <= r_p2x;
                r_p1y <= r_p2y;
                r_idx <= idx_p1;
            end
            S_FIN: begin
                if (acc_fits) begin
                    r_area <= r_acc[63:0];
                end else begin
                    r_area   <= r_acc[ACC_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    r_status <= ST_SAT;
                end
            end
            default: ;
        endcase
    end

    // Result word
    logic [31:0] cnt_ext;
    assign cnt_ext       = 32'(r_cnt);
    assign o_valid       = r_done;
    assign o_area        = r_area;
    assign o_status      = r_status;
    assign o_point_count = cnt_ext[8:0];

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (n_state != S_IDLE)) |=> busy)
        else $error("accepted word did not raise busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_DEPTH))
        else $error("point count above table depth");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LA_DIV) || (r_state == S_LB_DIV)) |-> (r_rem < r_dx))
        else $error("divider remainder not below divisor");
    a_zero_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_status == ST_FULL) || (o_status == ST_FEW))) |-> (o_area == 64'sd0))
        else $error("nonzero area with full or few status");
`endif

endmodule
